@@ design/rau_pkg.sv @@
// Package: widths, opcodes and status codes of the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;
    localparam int VALUE_WIDTH = 32;
    localparam int DEN_WIDTH   = VALUE_WIDTH - 1;
    localparam int WIDE_WIDTH  = 2 * VALUE_WIDTH;
    localparam int MAG_WIDTH   = WIDE_WIDTH + 1;
    localparam int CNT_WIDTH   = $clog2(MAG_WIDTH + 1);

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIVZERO  = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_SPARE    = 2'd3
    } t_status;
endpackage

@@ design/rau_if.sv @@
// Interfaces: valid/ready channels for operation words and result words.
`timescale 1ns / 1ps
interface rau_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             opcode;
    logic signed [rau_pkg::VALUE_WIDTH-1:0] a_num;
    logic [rau_pkg::DEN_WIDTH-1:0]          a_den;
    logic signed [rau_pkg::VALUE_WIDTH-1:0] b_num;
    logic [rau_pkg::DEN_WIDTH-1:0]          b_den;
    modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [rau_pkg::VALUE_WIDTH-1:0] res_num;
    logic [rau_pkg::DEN_WIDTH-1:0]          res_den;
    logic [1:0]                             status;
    modport source (output valid, res_num, res_den, status, input ready);
    modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

@@ design/rational_arithmetic_unit.sv @@
// Top level: rational arithmetic with gcd reduction on one shared subtract/shift unit.
//
//   channel  | dir | fields
//   i_op     | in  | opcode, a_num, a_den, b_num, b_den
//   o_res    | out | res_num, res_den, status
//
// After the accept cycle an item passes the set-up steps (two product pairs, sum,
// sign fix), then Euclid steps (one check and a restoring division, one
// conditional subtract per quotient bit), then the check that finds the gcd, the
// two divisions by it and packing. A zero denominator or a divide by zero goes
// straight to the result; a zero numerator skips the gcd. Synchronous active-low
// reset clears the sequencer. The result is held until taken; no new word is
// accepted meanwhile.
`timescale 1ns / 1ps
module rational_arithmetic_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    rau_in_if.sink    i_op,
    rau_out_if.source o_res
);
    localparam int VW = rau_pkg::VALUE_WIDTH;
    localparam int WW = rau_pkg::WIDE_WIDTH;
    localparam int MW = rau_pkg::MAG_WIDTH;
    localparam int CW = rau_pkg::CNT_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_SUM, S_FIX, S_GCD_CHK, S_DIV,
        S_RED_NUM, S_RED_DEN, S_PACK, S_OUT
    } t_state;

    typedef enum logic [1:0] { D_GCD, D_NUM, D_DEN } t_dsel;

    t_state r_state;
    t_dsel  r_dsel;
    logic [1:0] r_op;
    logic signed [VW-1:0] r_an, r_bn;
    logic [VW-1:0] r_ad, r_bd;
    logic signed [WW-1:0] r_p0, r_p1, r_p2;
    logic signed [MW-1:0] r_num;
    logic [MW-1:0] r_den;
    logic r_neg;
    logic [MW-1:0] r_x, r_y, r_mag, r_dmag;
    // restoring divider: quotient/dividend shift register, partial remainder
    logic [MW-1:0] r_q, r_rem, r_dvs;
    logic [CW-1:0] r_cnt;
    logic signed [VW-1:0] r_res_num;
    logic [VW-2:0] r_res_den;
    logic [1:0] r_status;
    logic r_valid;

    logic [MW:0] w_trial;
    logic [MW-1:0] w_maxv;
    logic signed [WW-1:0] w_prod_a, w_prod_b;

    assign w_trial  = {r_rem, r_q[MW-1]} - {1'b0, r_dvs};
    assign w_maxv   = (MW)'((65'd1 << (VW - 1)) - 65'd1);
    // one pair of 32x32 multipliers, registered before use
    assign w_prod_a = (WW)'(r_an) * (WW)'($signed({1'b0, r_bd}));
    assign w_prod_b = (WW)'(r_bn) * (WW)'($signed(r_ad));

    assign i_op.ready    = (r_state == S_IDLE);
    assign o_res.valid   = r_valid;
    assign o_res.res_num = r_res_num;
    assign o_res.res_den = r_res_den;
    assign o_res.status  = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_op.valid) begin
                        r_op <= i_op.opcode;
                        r_an <= i_op.a_num;
                        r_bn <= i_op.b_num;
                        r_ad <= {1'b0, i_op.a_den};
                        r_bd <= {1'b0, i_op.b_den};
                        if (i_op.a_den == '0 || i_op.b_den == '0 ||
                            (i_op.opcode == rau_pkg::OP_DIV && i_op.b_num == '0)) begin
                            r_res_num <= '0;
                            r_res_den <= '0;
                            r_status  <= rau_pkg::ST_DIVZERO;
                            r_valid   <= 1'b1;
                            r_state   <= S_OUT;
                        end else begin
                            r_state <= S_MUL1;
                        end
                    end
                end
                S_MUL1: begin
                    r_p0 <= w_prod_a;
                    r_p1 <= w_prod_b;
                    // steer ad into an for ad*bd next (all but divide), and an into ad for an*bn (multiply)
                    r_an <= (r_op == rau_pkg::OP_DIV) ? r_an : $signed(r_ad);
                    r_ad <= (r_op == rau_pkg::OP_MUL) ? r_an : r_ad;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    // ad*bd for every operation but divide; an*bn for multiply
                    r_p2 <= w_prod_a;
                    if (r_op == rau_pkg::OP_MUL)
                        r_p1 <= w_prod_b;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    case (r_op)
                        rau_pkg::OP_ADD: begin
                            r_num <= (MW)'(r_p0) + (MW)'(r_p1);
                            r_den <= (MW)'(r_p2);
                        end
                        rau_pkg::OP_SUB: begin
                            r_num <= (MW)'(r_p0) - (MW)'(r_p1);
                            r_den <= (MW)'(r_p2);
                        end
                        rau_pkg::OP_MUL: begin
                            r_num <= (MW)'(r_p1);
                            r_den <= (MW)'(r_p2);
                        end
                        default: begin
                            r_num <= (MW)'(r_p0);
                            r_den <= (MW)'(r_p1);
                        end
                    endcase
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    if (r_num == '0) begin
                        r_res_num <= '0;
                        r_res_den <= (VW-1)'(1);
                        r_status  <= rau_pkg::ST_OK;
                        r_valid   <= 1'b1;
                        r_state   <= S_OUT;
                    end else begin
                        // sign of num xor sign of den (only a divide can have den < 0)
                        r_neg  <= r_num[MW-1] ^ r_den[MW-1];
                        r_mag  <= r_num[MW-1] ? -r_num : r_num;
                        r_dmag <= r_den[MW-1] ? -r_den : r_den;
                        r_x    <= r_num[MW-1] ? -r_num : r_num;
                        r_y    <= r_den[MW-1] ? -r_den : r_den;
                        r_state <= S_GCD_CHK;
                    end
                end
                S_GCD_CHK: begin
                    if (r_y == '0) begin
                        r_q     <= r_mag;
                        r_dvs   <= r_x;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_dsel  <= D_NUM;
                        r_state <= S_DIV;
                    end else begin
                        r_q     <= r_x;
                        r_dvs   <= r_y;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_dsel  <= D_GCD;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_trial[MW]) begin
                        r_rem <= {r_rem[MW-2:0], r_q[MW-1]};
                        r_q   <= {r_q[MW-2:0], 1'b0};
                    end else begin
                        r_rem <= w_trial[MW-1:0];
                        r_q   <= {r_q[MW-2:0], 1'b1};
                    end
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(MW - 1)) begin
                        case (r_dsel)
                            D_GCD: begin
                                r_x     <= r_y;
                                r_y     <= w_trial[MW] ? {r_rem[MW-2:0], r_q[MW-1]}
                                                       : w_trial[MW-1:0];
                                r_state <= S_GCD_CHK;
                            end
                            D_NUM:   r_state <= S_RED_NUM;
                            default: r_state <= S_PACK;
                        endcase
                    end
                end
                S_RED_NUM: begin
                    r_mag   <= r_q;
                    r_q     <= r_dmag;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_dsel  <= D_DEN;
                    r_state <= S_DIV;
                end
                S_PACK: begin
                    r_valid <= 1'b1;
                    r_state <= S_OUT;
                    if (r_mag > w_maxv || r_q > w_maxv) begin
                        r_res_num <= '0;
                        r_res_den <= '0;
                        r_status  <= rau_pkg::ST_OVERFLOW;
                    end else begin
                        r_res_num <= r_neg ? -VW'(r_mag) : VW'(r_mag);
                        r_res_den <= (VW-1)'(r_q);
                        r_status  <= rau_pkg::ST_OK;
                    end
                end
                S_OUT: begin
                    if (o_res.ready) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    unused_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_state == S_OUT) else $error("result valid outside output state");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_op.ready && o_res.valid)) else $error("ready while result pending");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status != rau_pkg::ST_OK) |-> o_res.res_den == '0)
        else $error("error result with nonzero denominator");
    a_ok_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == rau_pkg::ST_OK) |-> o_res.res_den != '0)
        else $error("good result with zero denominator");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> $stable(r_res_num) && o_res.valid)
        else $error("result word changed while stalled");
endmodule
